>>> rtl/core/tlcs_pkg.sv
// shared types, register map and constants of the timed light chain sequencer
`timescale 1ns / 1ps
`default_nettype none

package tlcs_pkg;

   localparam int LED_COUNT  = 16;
   localparam int CNT_W      = 16;
   localparam int LED_W      = 16;
   localparam int REQ_DATA_W = 8;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // lit positions of the chain, cut to the width of the led word
   localparam logic [LED_W-1:0] LED_MASK = (LED_COUNT >= LED_W) ? {LED_W{1'b1}} :
      LED_W'((17'd1 << LED_COUNT) - 17'd1);

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // mode codes
   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_OLD_ON  = 3'd1;
   localparam logic [2:0] MODE_OLD_OFF = 3'd2;
   localparam logic [2:0] MODE_EVENING = 3'd3;
   localparam logic [2:0] MODE_NIGHT   = 3'd4;
   localparam logic [2:0] MODE_MORNING = 3'd5;
   localparam logic [2:0] MODE_DAY     = 3'd6;

   // register indexes
   localparam logic [2:0] REG_OLD_ON_TICKS  = 3'd0;
   localparam logic [2:0] REG_OLD_OFF_TICKS = 3'd1;
   localparam logic [2:0] REG_EVENING_TICKS = 3'd2;
   localparam logic [2:0] REG_NIGHT_TICKS   = 3'd3;
   localparam logic [2:0] REG_MORNING_TICKS = 3'd4;
   localparam logic [2:0] REG_DAY_TICKS     = 3'd5;
   localparam logic [2:0] REG_BLINK_TICKS   = 3'd6;
   localparam logic [2:0] REG_BLINK_PATTERN = 3'd7;

   // register reset values, lengths in ticks but for the blink pattern
   localparam logic [15:0] RST_OLD_ON_TICKS  = 16'd600;
   localparam logic [15:0] RST_OLD_OFF_TICKS = 16'd1800;
   localparam logic [15:0] RST_EVENING_TICKS = 16'd600;
   localparam logic [15:0] RST_NIGHT_TICKS   = 16'd600;
   localparam logic [15:0] RST_MORNING_TICKS = 16'd300;
   localparam logic [15:0] RST_DAY_TICKS     = 16'd900;
   localparam logic [15:0] RST_BLINK_TICKS   = 16'd50;
   localparam logic [15:0] RST_BLINK_PATTERN = 16'h5555;

   typedef struct packed {
      logic [15:0] old_on_ticks;
      logic [15:0] old_off_ticks;
      logic [15:0] evening_ticks;
      logic [15:0] night_ticks;
      logic [15:0] morning_ticks;
      logic [15:0] day_ticks;
      logic [15:0] blink_ticks;
      logic [15:0] blink_pattern;
   } cfg_type;

   typedef struct packed {
      logic [2:0]       mode;
      logic             latched;
      logic             blink_enable;
      logic             blink_phase;
      logic             all_on;
      logic [LED_W-1:0] blink_leds;
      logic [CNT_W-1:0] phase_elapsed;
      logic [CNT_W-1:0] blink_elapsed;
   } seq_state_type;

endpackage

`default_nettype wire

>>> rtl/core/tlcs_csr.sv
// configuration register file with apb-style access
`timescale 1ns / 1ps
`default_nettype none

module tlcs_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [tlcs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [tlcs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [tlcs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready,
   output tlcs_pkg::cfg_type                    cfg
);
   import tlcs_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_index;
   logic       wr_en;
   logic [15:0] wr_data;
   logic [15:0] rd_data;

   assign reg_index  = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign wr_data    = csr_pwdata[15:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_OLD_ON_TICKS:  cfg_in.old_on_ticks  = wr_data;
            REG_OLD_OFF_TICKS: cfg_in.old_off_ticks = wr_data;
            REG_EVENING_TICKS: cfg_in.evening_ticks = wr_data;
            REG_NIGHT_TICKS:   cfg_in.night_ticks   = wr_data;
            REG_MORNING_TICKS: cfg_in.morning_ticks = wr_data;
            REG_DAY_TICKS:     cfg_in.day_ticks     = wr_data;
            REG_BLINK_TICKS:   cfg_in.blink_ticks   = wr_data;
            REG_BLINK_PATTERN: cfg_in.blink_pattern = wr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_OLD_ON_TICKS:  rd_data = cfg_ff.old_on_ticks;
         REG_OLD_OFF_TICKS: rd_data = cfg_ff.old_off_ticks;
         REG_EVENING_TICKS: rd_data = cfg_ff.evening_ticks;
         REG_NIGHT_TICKS:   rd_data = cfg_ff.night_ticks;
         REG_MORNING_TICKS: rd_data = cfg_ff.morning_ticks;
         REG_DAY_TICKS:     rd_data = cfg_ff.day_ticks;
         REG_BLINK_TICKS:   rd_data = cfg_ff.blink_ticks;
         REG_BLINK_PATTERN: rd_data = cfg_ff.blink_pattern;
         default:           rd_data = '0;
      endcase
   end

   assign csr_prdata = {{(CSR_DATA_W-16){1'b0}}, rd_data};
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.old_on_ticks  <= RST_OLD_ON_TICKS;
         cfg_ff.old_off_ticks <= RST_OLD_OFF_TICKS;
         cfg_ff.evening_ticks <= RST_EVENING_TICKS;
         cfg_ff.night_ticks   <= RST_NIGHT_TICKS;
         cfg_ff.morning_ticks <= RST_MORNING_TICKS;
         cfg_ff.day_ticks     <= RST_DAY_TICKS;
         cfg_ff.blink_ticks   <= RST_BLINK_TICKS;
         cfg_ff.blink_pattern <= RST_BLINK_PATTERN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/tlcs_step.sv
// next-state and led word logic for one tick
`timescale 1ns / 1ps
`default_nettype none

module tlcs_step (
   input  tlcs_pkg::seq_state_type          cur,
   input  tlcs_pkg::cfg_type                cfg,
   input  wire logic                        old_mode_switch,
   input  wire logic                        new_mode_switch,
   output tlcs_pkg::seq_state_type          nxt,
   output logic [tlcs_pkg::LED_W-1:0]       led_word
);
   import tlcs_pkg::*;

   seq_state_type    s;
   logic [CNT_W-1:0] phase_len;
   logic [2:0]       adv_mode;
   logic             timed;

   always_comb begin
      s         = cur;
      phase_len = '0;
      adv_mode  = MODE_IDLE;
      timed     = 1'b0;

      if (!old_mode_switch && !new_mode_switch) begin
         s.phase_elapsed = '0;
         s.blink_elapsed = '0;
         s.mode          = MODE_IDLE;
         s.latched       = 1'b0;
         s.blink_enable  = 1'b0;
      end
      // old switch is checked first so it wins a tie
      if (old_mode_switch && !s.latched) begin
         s.mode    = MODE_OLD_ON;
         s.latched = 1'b1;
      end
      if (new_mode_switch && !s.latched) begin
         s.mode    = MODE_EVENING;
         s.latched = 1'b1;
      end

      unique case (s.mode)
         MODE_OLD_ON: begin
            s.blink_enable = 1'b1;
            phase_len = cfg.old_on_ticks;
            adv_mode  = MODE_OLD_OFF;
            timed     = 1'b1;
         end
         MODE_OLD_OFF: begin
            s.blink_enable = 1'b0;
            s.blink_leds   = '0;
            phase_len = cfg.old_off_ticks;
            adv_mode  = MODE_OLD_ON;
            timed     = 1'b1;
         end
         MODE_EVENING: begin
            s.all_on  = 1'b1;
            phase_len = cfg.evening_ticks;
            adv_mode  = MODE_NIGHT;
            timed     = 1'b1;
         end
         MODE_NIGHT: begin
            s.all_on  = 1'b0;
            phase_len = cfg.night_ticks;
            adv_mode  = MODE_MORNING;
            timed     = 1'b1;
         end
         MODE_MORNING: begin
            s.all_on  = 1'b1;
            phase_len = cfg.morning_ticks;
            adv_mode  = MODE_DAY;
            timed     = 1'b1;
         end
         MODE_DAY: begin
            s.all_on  = 1'b0;
            phase_len = cfg.day_ticks;
            adv_mode  = MODE_EVENING;
            timed     = 1'b1;
         end
         default: begin
            s.all_on     = 1'b0;
            s.blink_leds = '0;
         end
      endcase

      if (timed && (s.phase_elapsed >= phase_len)) begin
         s.mode          = adv_mode;
         s.phase_elapsed = '0;
      end

      if (s.blink_enable) begin
         if (s.blink_elapsed >= cfg.blink_ticks) begin
            s.blink_phase   = ~s.blink_phase;
            s.blink_elapsed = '0;
         end
         s.blink_leds = (s.blink_phase ? ~cfg.blink_pattern : cfg.blink_pattern) & LED_MASK;
      end

      led_word = (s.all_on ? LED_MASK : '0) | s.blink_leds;

      // elapsed counters stop at full scale
      if (s.phase_elapsed != CNT_MAX) begin
         s.phase_elapsed = s.phase_elapsed + 1'b1;
      end
      if (s.blink_elapsed != CNT_MAX) begin
         s.blink_elapsed = s.blink_elapsed + 1'b1;
      end

      nxt = s;
   end

endmodule

`default_nettype wire

>>> rtl/core/timed_light_chain_sequencer_top.sv
// top level of the timed light chain sequencer
// an accepted request's led word is registered into rsp_tdata at the edge that accepts it
// throughput: one request per cycle while no result is held or rsp_tready is high
// a held result does not block the next request once the result side takes it in the same cycle
// reset: synchronous, active high; clears mode, latch, blink and counter state, empties the
// result register and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none

module timed_light_chain_sequencer_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request: [0] old_mode_switch, [1] new_mode_switch, [7:2] zero
   input  wire logic [tlcs_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // result: [15:0] led_word
   output logic      [tlcs_pkg::LED_W-1:0]      rsp_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [tlcs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [tlcs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [tlcs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready
);
   import tlcs_pkg::*;

   cfg_type          cfg;
   seq_state_type    state_ff;
   seq_state_type    state_in;
   logic [LED_W-1:0] led_word;
   logic [LED_W-1:0] rsp_tdata_ff;
   logic             rsp_tvalid_ff;
   logic             req_fire;

   tlcs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tlcs_step u_step (
      .cur             (state_ff),
      .cfg             (cfg),
      .old_mode_switch (req_tdata[0]),
      .new_mode_switch (req_tdata[1]),
      .nxt             (state_in),
      .led_word        (led_word)
   );

   assign req_tready = ~rsp_tvalid_ff | rsp_tready;
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            state_ff <= state_in;
         end
         if (req_fire) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_tdata_ff <= led_word;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/tlcs_checker.sv
// port-level checks for the timed light chain sequencer and their binding
`timescale 1ns / 1ps
`default_nettype none

module tlcs_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic [tlcs_pkg::REQ_DATA_W-1:0] req_tdata,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic [tlcs_pkg::LED_W-1:0]      rsp_tdata,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready
);

   // a held result keeps its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // every accepted request yields a result on the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request gave no result");

   // an empty result register never holds off requests
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty result register");

   // both switches off means a dark chain
   a_idle_dark: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tdata[0] && !req_tdata[1] |=> rsp_tdata == '0)
      else $error("idle request lit leds");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind timed_light_chain_sequencer_top tlcs_checker u_tlcs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tdata  (req_tdata),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire
